[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define WPTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define WPTS_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define WPTS_ASSERT(lbl, clk, rst_n, prop, msg)

`define WPTS_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[hdl/wpts_pkg.sv]
// Types and constants of the windowed phase time statistics block.
package wpts_pkg;

  localparam int unsigned METRIC_COUNT = 12;
  localparam int unsigned PHASE_COUNT  = 11;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned METRIC_W     = 4;
  localparam int unsigned PHASE_W      = 4;
  localparam int unsigned SAMPLE_W     = 7;

  localparam logic [METRIC_W-1:0] LAST_METRIC = 4'd11;
  localparam logic [TIME_W-1:0]   TIME_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FRAME = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_PUSH,
    ST_CLEAR,
    ST_QSTART,
    ST_QCUR,
    ST_SCAN,
    ST_DRAIN,
    ST_DSTART,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [METRIC_W-1:0] metric;
    logic [TIME_W-1:0]   current_value;
    logic [TIME_W-1:0]   window_minimum;
    logic [TIME_W-1:0]   window_maximum;
    logic [TIME_W-1:0]   window_mean;
    logic [SAMPLE_W-1:0] sample_count;
    logic [TIME_W-1:0]   frame_number;
    logic                last;
  } out_item_t;

endpackage

[hdl/wpts_if.sv]
// Handshake channels of the statistics block: command input and result output.
interface wpts_in_if import wpts_pkg::*;;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [PHASE_W-1:0]  phase;
  logic [TIME_W-1:0]   time_value;

  modport source (output valid, output opcode, output phase, output time_value, input ready);
  modport sink   (input valid, input opcode, input phase, input time_value, output ready);
endinterface

interface wpts_out_if import wpts_pkg::*;;
  logic                valid;
  logic                ready;
  logic [METRIC_W-1:0] metric;
  logic [TIME_W-1:0]   current_value;
  logic [TIME_W-1:0]   window_minimum;
  logic [TIME_W-1:0]   window_maximum;
  logic [TIME_W-1:0]   window_mean;
  logic [SAMPLE_W-1:0] sample_count;
  logic [TIME_W-1:0]   frame_number;
  logic                last;

  modport source (output valid, output metric, output current_value, output window_minimum,
                  output window_maximum, output window_mean, output sample_count,
                  output frame_number, output last, input ready);
  modport sink   (input valid, input metric, input current_value, input window_minimum,
                  input window_maximum, input window_mean, input sample_count,
                  input frame_number, input last, output ready);
endinterface

[hdl/wpts_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module wpts_ram #(
  parameter int unsigned DEPTH = 12,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/wpts_div.sv]
// Bit-serial restoring divider for the window mean, one quotient bit per cycle.
module wpts_div import wpts_pkg::*; #(
  parameter int unsigned NUM_W = 39,
  parameter int unsigned DEN_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  numer,
  input  logic [DEN_W-1:0]  denom,
  output logic              done,
  output logic [TIME_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   shifted, diff;
  logic             ge;

  always_comb begin
    shifted = {rem_r, q_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    q_nxt   = {q_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= numer;
      den_r <= denom;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r[TIME_W-1:0];

endmodule

[hdl/windowed_phase_time_statistics.sv]
// Windowed phase time statistics: per-frame time metrics and rolling min, max and mean.
//
// The block keeps twelve metrics of the frame in progress (metric 0 the frame delta,
// metrics 1..11 the phase accumulators) in a small RAM, and a ring of the last
// HISTORY_DEPTH finished frames in a second RAM of HISTORY_DEPTH*12 words. It takes one
// item at a time. An add-phase item reads its accumulator, adds with saturation and
// writes it back. A frame-start item copies the finished frame into the ring through
// the single read port of the metric RAM, then loads the new delta and clears the
// phases (only the load and clear on the very first frame). A query emits 12 result
// items; for each, the history RAM is scanned one stored frame per cycle through its
// one read port, then the bit-serial divider forms the floor mean one bit per cycle.
// A query also waits whenever the result side stalls. An empty ring skips scan and
// divide and reports zero minimum, maximum, mean and sample count. After reset the
// metric RAM is cleared in one pass, with the input held off, so the frame in
// progress starts from zero. The ring RAM is not cleared after reset; only written
// slots are ever read. A finished result sits in an output register, so the block
// returns to accepting items while the last result of a query still waits to be
// taken.
`include "assert_macros.svh"

module windowed_phase_time_statistics import wpts_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  wpts_in_if.sink           in_ch,
  wpts_out_if.source        out_ch
);

  // Widths that follow from the ring depth
  localparam int unsigned FW    = $clog2(HISTORY_DEPTH + 1);            // fill count
  localparam int unsigned SW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1; // slot
  localparam int unsigned HAW   = $clog2(HISTORY_DEPTH * METRIC_COUNT); // history addr
  localparam int unsigned SUM_W = TIME_W + FW;                          // window sum
  localparam int unsigned CAW   = $clog2(METRIC_COUNT);                 // metric RAM addr

  state_t state_r, state_nxt;

  // Ring bookkeeping
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [SW-1:0]     oldest_r, oldest_nxt;
  logic [TIME_W-1:0] frames_r, frames_nxt;

  // Item capture and sequencing
  logic [TIME_W-1:0] tval_r, tval_nxt;
  logic [CAW-1:0]    addr_r, addr_nxt;      // metric being added to
  logic [CAW:0]      k_r, k_nxt;            // copy / clear step, runs to 12
  logic [SW-1:0]     push_slot_r, push_slot_nxt;
  logic [METRIC_W-1:0] mi_r, mi_nxt;        // metric under query

  // Scan and accumulate
  logic [SW-1:0]     scan_slot_r, scan_slot_nxt;
  logic [FW-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              first_r, first_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [TIME_W-1:0] min_r, min_nxt;
  logic [TIME_W-1:0] max_r, max_nxt;
  logic [TIME_W-1:0] cur_val_r, cur_val_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // RAM ports
  logic              cur_we;
  logic [CAW-1:0]    cur_waddr, cur_raddr;
  logic [TIME_W-1:0] cur_wdata, cur_rdata;
  logic              hist_we;
  logic [HAW-1:0]    hist_waddr, hist_raddr;
  logic [TIME_W-1:0] hist_rdata;

  // Divider
  logic              div_start, div_done;
  logic [TIME_W-1:0] div_quot;

  // Local helpers
  logic              in_fire;
  logic [TIME_W:0]   add_sum;
  logic [FW:0]       slot_sum;
  logic [SW-1:0]     oldest_inc, scan_inc;

  assign in_fire = in_ch.valid && in_ch.ready;

  wpts_ram #(.DEPTH(METRIC_COUNT), .WIDTH(TIME_W)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  wpts_ram #(.DEPTH(HISTORY_DEPTH * METRIC_COUNT), .WIDTH(TIME_W)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (cur_rdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  wpts_div #(.NUM_W(SUM_W), .DEN_W(FW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (sum_r),
    .denom (fill_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Slot arithmetic: each sum stays below twice the depth, so one compare-subtract wraps it
  always_comb begin
    slot_sum   = (FW+1)'(oldest_r) + (FW+1)'(fill_r);
    oldest_inc = (oldest_r == SW'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
    scan_inc   = (scan_slot_r == SW'(HISTORY_DEPTH - 1)) ? '0 : scan_slot_r + 1'b1;
    add_sum    = {1'b0, cur_rdata} + {1'b0, tval_r};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.opcode)
            OP_ADD: begin
              if (in_ch.phase < PHASE_W'(PHASE_COUNT)) state_nxt = ST_ADD;
            end
            OP_FRAME: state_nxt = (frames_r != '0) ? ST_PUSH : ST_CLEAR;
            OP_QUERY: state_nxt = ST_QSTART;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD:    state_nxt = ST_IDLE;
      ST_PUSH: begin
        if (k_r == (CAW+1)'(METRIC_COUNT)) state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (k_r == (CAW+1)'(METRIC_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_QSTART: state_nxt = ST_QCUR;
      ST_QCUR:   state_nxt = (fill_r == '0) ? ST_EMIT : ST_SCAN;
      ST_SCAN: begin
        if (scan_cnt_r == fill_r - 1'b1) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = (mi_r == LAST_METRIC) ? ST_IDLE : ST_QSTART;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    frames_nxt    = frames_r;
    tval_nxt      = tval_r;
    addr_nxt      = addr_r;
    k_nxt         = k_r;
    push_slot_nxt = push_slot_r;
    mi_nxt        = mi_r;
    scan_slot_nxt = scan_slot_r;
    scan_cnt_nxt  = scan_cnt_r;
    rd_vld_nxt    = 1'b0;
    first_nxt     = first_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    cur_val_nxt   = cur_val_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_item_nxt  = out_item_r;

    in_ch.ready = (state_r == ST_IDLE);
    cur_we      = 1'b0;
    cur_waddr   = addr_r;
    cur_wdata   = add_sum[TIME_W] ? TIME_MAX : add_sum[TIME_W-1:0];
    cur_raddr   = '0;
    hist_we     = 1'b0;
    hist_waddr  = HAW'(HAW'(push_slot_r) * HAW'(METRIC_COUNT) + HAW'(k_r - 1'b1));
    hist_raddr  = HAW'(HAW'(scan_slot_r) * HAW'(METRIC_COUNT) + HAW'(mi_r));
    div_start   = 1'b0;

    // History read data lands in the cycle after the read is issued
    if (rd_vld_r) begin
      sum_nxt = sum_r + SUM_W'(hist_rdata);
      if (first_r) begin
        min_nxt   = hist_rdata;
        max_nxt   = hist_rdata;
        first_nxt = 1'b0;
      end else begin
        if (hist_rdata < min_r) min_nxt = hist_rdata;
        if (hist_rdata > max_r) max_nxt = hist_rdata;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          tval_nxt = in_ch.time_value;
          addr_nxt = CAW'(in_ch.phase + 1'b1);
          k_nxt    = '0;
          mi_nxt   = '0;
          case (in_ch.opcode)
            OP_ADD: begin
              cur_raddr = CAW'(in_ch.phase + 1'b1);
            end
            OP_FRAME: begin
              frames_nxt = frames_r + 1'b1;
              if (frames_r != '0) begin
                push_slot_nxt = (slot_sum >= (FW+1)'(HISTORY_DEPTH))
                              ? SW'(slot_sum - (FW+1)'(HISTORY_DEPTH)) : SW'(slot_sum);
                if (fill_r != FW'(HISTORY_DEPTH)) begin
                  fill_nxt = fill_r + 1'b1;
                end else begin
                  oldest_nxt = oldest_inc;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        cur_we = 1'b1;
      end
      ST_PUSH: begin
        // Read metric k while writing metric k-1 into the ring slot
        cur_raddr = CAW'(k_r);
        hist_we   = (k_r != '0);
        k_nxt     = (k_r == (CAW+1)'(METRIC_COUNT)) ? '0 : k_r + 1'b1;
      end
      ST_CLEAR: begin
        cur_we    = 1'b1;
        cur_waddr = CAW'(k_r);
        cur_wdata = (k_r == '0) ? tval_r : '0;
        k_nxt     = k_r + 1'b1;
      end
      ST_QSTART: begin
        cur_raddr = CAW'(mi_r);
      end
      ST_QCUR: begin
        cur_val_nxt   = cur_rdata;
        scan_slot_nxt = oldest_r;
        scan_cnt_nxt  = '0;
        first_nxt     = 1'b1;
        sum_nxt       = '0;
        min_nxt       = '0;
        max_nxt       = '0;
      end
      ST_SCAN: begin
        rd_vld_nxt    = 1'b1;
        scan_slot_nxt = scan_inc;
        scan_cnt_nxt  = scan_cnt_r + 1'b1;
      end
      ST_DSTART: begin
        div_start = 1'b1;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.metric         = mi_r;
          out_item_nxt.current_value  = cur_val_r;
          out_item_nxt.window_minimum = min_r;
          out_item_nxt.window_maximum = max_r;
          out_item_nxt.window_mean    = (fill_r == '0) ? '0 : div_quot;
          out_item_nxt.sample_count   = SAMPLE_W'(fill_r);
          out_item_nxt.frame_number   = frames_r;
          out_item_nxt.last           = (mi_r == LAST_METRIC);
          mi_nxt                      = mi_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state; reset starts with a clearing pass over the metric RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      fill_r      <= '0;
      oldest_r    <= '0;
      frames_r    <= '0;
      tval_r      <= '0;
      k_r         <= '0;
      mi_r        <= '0;
      scan_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      frames_r    <= frames_nxt;
      tval_r      <= tval_nxt;
      k_r         <= k_nxt;
      mi_r        <= mi_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    push_slot_r <= push_slot_nxt;
    scan_slot_r <= scan_slot_nxt;
    sum_r       <= sum_nxt;
    min_r       <= min_nxt;
    max_r       <= max_nxt;
    cur_val_r   <= cur_val_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.metric         = out_item_r.metric;
  assign out_ch.current_value  = out_item_r.current_value;
  assign out_ch.window_minimum = out_item_r.window_minimum;
  assign out_ch.window_maximum = out_item_r.window_maximum;
  assign out_ch.window_mean    = out_item_r.window_mean;
  assign out_ch.sample_count   = out_item_r.sample_count;
  assign out_ch.frame_number   = out_item_r.frame_number;
  assign out_ch.last           = out_item_r.last;

  // Ring never holds more than its depth
  `WPTS_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FW'(HISTORY_DEPTH), "ring fill beyond depth")
  // The oldest pointer only moves once the ring is full
  `WPTS_ASSERT(a_oldest_full, clk, rst_n, (fill_r != FW'(HISTORY_DEPTH)) |-> (oldest_r == '0), "oldest moved before ring full")
  // The scan never issues more reads than there are stored frames
  `WPTS_ASSERT(a_scan_bound, clk, rst_n, (state_r == ST_SCAN) |-> (scan_cnt_r < fill_r), "scan beyond stored frames")
  // The closing item of a query carries the last metric
  `WPTS_ASSERT(a_last_metric, clk, rst_n, (out_valid_r && out_item_r.last) |-> (out_item_r.metric == LAST_METRIC), "last flag on wrong metric")
  // The divider is only waited on after it has been started
  `WPTS_ASSERT(a_div_order, clk, rst_n, ($rose(state_r == ST_DIV)) |-> ($past(state_r) == ST_DSTART), "divide wait without start")

endmodule

[sim/wpts_checker.sv]
// Checker for the phase time statistics block: mirrors its state and compares each result item.
module wpts_checker import wpts_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  wpts_in_if   in_mon,
  wpts_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  // Shadow copy of the block's state.
  logic [TIME_W-1:0] frame_now [METRIC_COUNT];
  logic [TIME_W-1:0] ring [HISTORY_DEPTH][METRIC_COUNT];
  int unsigned       ring_head;
  int unsigned       ring_used;
  logic [TIME_W-1:0] frames_seen;

  out_item_t due_stats[$];

  task automatic update_stats(input logic [1:0] op, input logic [PHASE_W-1:0] ph,
                              input logic [TIME_W-1:0] tv);
    logic [TIME_W:0]   total;
    logic [63:0]       acc;
    logic [TIME_W-1:0] v;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    int unsigned       slot;
    out_item_t         r;
    case (op)
      OP_ADD: begin
        // phase none and codes above it leave everything alone
        if (ph < PHASE_COUNT) begin
          total = {1'b0, frame_now[ph + 1]} + {1'b0, tv};
          frame_now[ph + 1] = total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
        end
      end
      OP_FRAME: begin
        // no push while the frame count reads zero
        if (frames_seen != 0) begin
          slot = (ring_head + ring_used) % HISTORY_DEPTH;
          for (int m = 0; m < METRIC_COUNT; m++) ring[slot][m] = frame_now[m];
          if (ring_used < HISTORY_DEPTH) ring_used++;
          else ring_head = (ring_head + 1) % HISTORY_DEPTH;
        end
        frames_seen++;
        frame_now[0] = tv;
        for (int m = 1; m < METRIC_COUNT; m++) frame_now[m] = '0;
      end
      OP_QUERY: begin
        for (int m = 0; m < METRIC_COUNT; m++) begin
          acc = '0;
          lo  = '0;
          hi  = '0;
          for (int unsigned i = 0; i < ring_used; i++) begin
            v = ring[(ring_head + i) % HISTORY_DEPTH][m];
            acc += v;
            if (i == 0) begin
              lo = v;
              hi = v;
            end else begin
              if (v < lo) lo = v;
              if (v > hi) hi = v;
            end
          end
          r.metric         = METRIC_W'(m);
          r.current_value  = frame_now[m];
          r.window_minimum = lo;
          r.window_maximum = hi;
          r.window_mean    = (ring_used != 0) ? TIME_W'(acc / ring_used) : '0;
          r.sample_count   = SAMPLE_W'(ring_used);
          r.frame_number   = frames_seen;
          r.last           = (m == METRIC_COUNT - 1);
          due_stats.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic match_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_stat();
    out_item_t want;
    if (due_stats.size() == 0) begin
      $error("stat item with no query outstanding: metric %0d", out_mon.metric);
      fail_count++;
    end else begin
      want = due_stats.pop_front();
      match_field("metric", TIME_W'(want.metric), TIME_W'(out_mon.metric));
      match_field("current_value", want.current_value, out_mon.current_value);
      match_field("window_minimum", want.window_minimum, out_mon.window_minimum);
      match_field("window_maximum", want.window_maximum, out_mon.window_maximum);
      match_field("window_mean", want.window_mean, out_mon.window_mean);
      match_field("sample_count", TIME_W'(want.sample_count), TIME_W'(out_mon.sample_count));
      match_field("frame_number", want.frame_number, out_mon.frame_number);
      match_field("last", TIME_W'(want.last), TIME_W'(out_mon.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < METRIC_COUNT; m++) frame_now[m] = '0;
      ring_head   = 0;
      ring_used   = 0;
      frames_seen = '0;
      fail_count  = 0;
      due_stats.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        update_stats(in_mon.opcode, in_mon.phase, in_mon.time_value);
      if (out_mon.valid && out_mon.ready) check_stat();
    end
    pending = due_stats.size();
  end

endmodule

[sim/tb.sv]
// Top of the phase time statistics testbench: clock, reset, stimulus, watchdog and verdict.
module tb import wpts_pkg::*;;

  localparam int unsigned HISTORY_DEPTH = 64;

  // Useful items in the random part; the final stretch runs without idling.
  localparam int unsigned ITEM_TARGET = 380;
  localparam int unsigned CALM_ITEMS  = 50;

  // Long receiver hold-off, so the block fills its output register and
  // backs up onto the command side.
  localparam int unsigned HOLD_CYCLES = 400;

  // Slowest gap between two accepted items, full ring: a query's scan and divide
  // for each result, receiver stalls on either side and a frame push; the
  // hold-off above dominates.  Taken several times over.
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  // Wait past a full-ring query at the end so a stray result behind a
  // result-less item still shows up.
  localparam int unsigned DRAIN_CYCLES = 1500;

  localparam logic [1:0]         OP_UNUSED  = 2'd3;
  localparam logic [PHASE_W-1:0] PHASE_NONE = 4'd11;

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  wpts_in_if  in_ch ();
  wpts_out_if out_ch ();

  int fail_count;
  int pending;

  // Shared with the receiver process.
  bit hold_go = 1'b0;
  bit calm    = 1'b0;

  int quiet = 0;

  windowed_phase_time_statistics #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wpts_checker #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mix of magnitudes: small values keep sums and means moving, values near
  // the top force the phase accumulators into saturation.
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 32'h0000_FFFF);
      2:       return TIME_MAX - $urandom_range(0, 32'h0000_FFFF);
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  // Occasional sender gap, none in the calm stretch.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
  endtask

  // Offer one item and hold it until the block takes it.  ready is read at
  // the rising edge, i.e. the value that the block's edge itself sees.
  task automatic offer(input logic [1:0] op, input logic [PHASE_W-1:0] ph,
                       input logic [TIME_W-1:0] tv);
    sender_gap();
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.phase      <= ph;
    in_ch.time_value <= tv;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // An item the block must ignore: unused opcode, or a phase of none or above.
  task automatic offer_noise();
    if ($urandom_range(0, 1) == 0)
      offer(OP_UNUSED, PHASE_W'($urandom_range(0, 15)), $urandom);
    else
      offer(OP_ADD, PHASE_W'($urandom_range(PHASE_NONE, 15)), pick_time());
  endtask

  // Receiver: random stall bursts between ready runs, one long hold-off on
  // request, always ready in the calm stretch.
  initial begin
    int stall_left;
    int run_left;
    stall_left   = 0;
    run_left     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go    = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (calm) begin
        stall_left = 0;
      end else if (stall_left == 0 && run_left == 0) begin
        if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 9);
        else run_left = $urandom_range(1, 30);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int useful;
    int adds;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_ADD;
    in_ch.phase      = '0;
    in_ch.time_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Query on an empty ring before any frame: all statistics zero.
    offer(OP_QUERY, 4'd0, '0);
    // Phase time before the first frame, then saturation of the sum.
    offer(OP_ADD, 4'd0, TIME_MAX);
    offer(OP_ADD, 4'd0, 32'd1);
    offer(OP_ADD, 4'd10, 32'h0001_0000);
    // Phase none and the highest phase code: ignored.
    offer(OP_ADD, PHASE_NONE, 32'd5);
    offer(OP_ADD, 4'd15, TIME_MAX);
    // Unused opcode: no state change, no results.
    offer(OP_UNUSED, 4'd15, TIME_MAX);
    // First frame: nothing pushed.
    offer(OP_FRAME, 4'd15, TIME_MAX);
    offer(OP_ADD, 4'd5, 32'h0000_8000);
    offer(OP_QUERY, 4'd15, TIME_MAX);
    // Second frame pushes the first one.
    offer(OP_FRAME, 4'd0, '0);
    offer(OP_ADD, 4'd0, TIME_MAX);
    offer(OP_ADD, 4'd0, TIME_MAX);
    offer(OP_ADD, 4'd10, '0);
    offer(OP_FRAME, 4'd7, 32'h0001_0000);
    offer(OP_QUERY, 4'd0, '0);
    offer(OP_ADD, 4'd3, 32'h1234_5678);

    // Back-pressure: the receiver holds off while a query and further items
    // are offered, so the block stalls its command side.
    hold_go = 1'b1;
    offer(OP_QUERY, 4'd0, '0);
    repeat (8) begin
      if ($urandom_range(0, 3) == 0)
        offer(OP_FRAME, PHASE_W'($urandom_range(0, 15)), pick_time());
      else offer(OP_ADD, PHASE_W'($urandom_range(0, 10)), pick_time());
    end

    // Random part: frames with a handful of phase times each, queries now
    // and then, a little noise mixed in.  About 95 frames, so the ring fills
    // and wraps well before the end.
    useful = 0;
    while (useful < ITEM_TARGET) begin
      if (useful >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      offer(OP_FRAME, PHASE_W'($urandom_range(0, 15)), pick_time());
      useful++;
      adds = $urandom_range(0, 6);
      repeat (adds) begin
        if ($urandom_range(0, 9) == 0) begin
          offer_noise();
        end else begin
          offer(OP_ADD, PHASE_W'($urandom_range(0, 10)), pick_time());
          useful++;
        end
      end
      if ($urandom_range(0, 19) < 7) begin
        offer(OP_QUERY, PHASE_W'($urandom_range(0, 15)), $urandom);
        useful++;
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain: every expected item in, then a quiet tail for strays.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
